>>> rtl/ers_pkg.sv
package ers_pkg;

  // number of served floors, floor f owns request bit f-1
  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 5;
  localparam int KIND_W  = 2;
  localparam int DIR_W   = 2;
  // scan index must hold 1..FLOORS and the floor field
  localparam int IDX_MIN = $clog2(FLOORS + 2);
  localparam int SCAN_W  = (IDX_MIN > FLOOR_W) ? IDX_MIN : FLOOR_W;
  localparam int BIT_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CALL   = 2'd0,
    KIND_ARRIVE = 2'd1,
    KIND_PASS   = 2'd2
  } kind_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STAY = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PICK,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic call;
    logic arrive;
    logic set_here;
    logic pick_step;
    logic scan_init;
    logic scan_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              floor_ok;
    logic [KIND_W-1:0] kind;
    logic              busy;
    logic              at_goal;
    logic              pick_hit;
    logic              pick_last;
    logic              scan_hit;
    logic              scan_last;
    logic              emit_needed;
    logic              slot_free;
  } status_t;

endpackage

>>> rtl/ers_in_if.sv
interface ers_in_if import ers_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FLOOR_W-1:0] floor;

  modport source(output valid, output kind, output floor, input ready);
  modport sink(input valid, input kind, input floor, output ready);
endinterface

>>> rtl/ers_out_if.sv
interface ers_out_if import ers_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] stop_floor;
  logic [DIR_W-1:0]   heading;

  modport source(output valid, output stop_floor, output heading, input ready);
  modport sink(input valid, input stop_floor, input heading, output ready);
endinterface

>>> rtl/elevator_request_scheduler.sv
// elevator request scheduler: takes call, arrival and passing words, keeps a
// bitmap of requested floors with the current floor, goal and direction, and
// answers a call, or an arrival that leaves a stop to serve, with one word
// naming the next floor and the heading (1 up, 2 down). one word is worked on
// at a time; the goal search and the stop search each walk the request
// bitmap one floor per cycle. the result sits in an output register, so a new
// word is taken while the previous result still waits on out_chan.ready; the
// next result then waits in the finish state until that register frees up.
// words with a floor outside 1..FLOORS or an unknown kind are dropped.
module elevator_request_scheduler import ers_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ers_in_if.sink    in_chan,
  ers_out_if.source out_chan
);

  cmd_t    cmd;
  status_t sts;

  // sequencer: decode, goal search, stop search, result hand-off
  ers_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // request bitmap, floor state, scan index and result register
  ers_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_chan.kind),
    .in_floor       (in_chan.floor),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_stop_floor (out_chan.stop_floor),
    .out_heading    (out_chan.heading)
  );

endmodule

>>> rtl/ers_ctrl.sv
module ers_ctrl import ers_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (sts.floor_ok) begin
          unique case (sts.kind)
            KIND_CALL:   state_nxt = ST_SCAN_INIT;
            KIND_ARRIVE: begin
              if (sts.busy) state_nxt = sts.at_goal ? ST_PICK : ST_SCAN_INIT;
            end
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PICK: begin
        if (sts.pick_hit || sts.pick_last) state_nxt = ST_SCAN_INIT;
      end
      ST_SCAN_INIT: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_hit || sts.scan_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.emit_needed || sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        if (sts.floor_ok) begin
          unique case (sts.kind)
            KIND_CALL:   cmd.call = 1'b1;
            KIND_ARRIVE: cmd.arrive = sts.busy;
            KIND_PASS:   cmd.set_here = 1'b1;
            default:     cmd = '0;
          endcase
        end
      end
      ST_PICK:      cmd.pick_step = 1'b1;
      ST_SCAN_INIT: cmd.scan_init = 1'b1;
      ST_SCAN:      cmd.scan_step = 1'b1;
      ST_FINISH:    cmd.finish = !sts.emit_needed || sts.slot_free;
      default:      cmd = '0;
    endcase
  end

endmodule

>>> rtl/ers_datapath.sv
module ers_datapath import ers_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [FLOOR_W-1:0] in_floor,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [FLOOR_W-1:0] out_stop_floor,
  output logic [DIR_W-1:0]   out_heading
);

  // scheduler state
  logic [FLOORS-1:0]  req_r, req_nxt;
  logic [FLOOR_W-1:0] here_r, here_nxt;
  logic [FLOOR_W-1:0] goal_r, goal_nxt;
  dir_t               dir_r, dir_nxt;
  logic               busy_r, busy_nxt;
  // word being worked on
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  logic [SCAN_W-1:0]  idx_r, idx_nxt;
  logic [FLOOR_W-1:0] stop_r, stop_nxt;
  logic               scan_up_r, scan_up_nxt;
  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [FLOOR_W-1:0] out_stop_r, out_stop_nxt;
  dir_t               out_dir_r, out_dir_nxt;

  logic [SCAN_W-1:0]  floor_ext, floor_m1, idx_m1;
  logic [BIT_W-1:0]   floor_sel, idx_sel;
  logic               idx_hit, last_up, last_dn;
  logic [FLOOR_W-1:0] goal_base, goal_call;
  dir_t               dir_new;

  assign floor_ext = SCAN_W'(floor_r);
  assign floor_m1  = floor_ext - SCAN_W'(1);
  assign floor_sel = floor_m1[BIT_W-1:0];
  assign idx_m1    = idx_r - SCAN_W'(1);
  assign idx_sel   = idx_m1[BIT_W-1:0];
  assign idx_hit   = req_r[idx_sel];
  assign last_up   = (idx_r == SCAN_W'(FLOORS));
  assign last_dn   = (idx_r == SCAN_W'(1));

  // a call may push the goal further along the travel direction
  assign goal_base = (goal_r == '0) ? floor_r : goal_r;
  assign goal_call = ((dir_r == DIR_UP && floor_r > goal_base) ||
                      (dir_r == DIR_DOWN && floor_r < goal_base)) ? floor_r : goal_base;
  assign dir_new   = (here_r > goal_r) ? DIR_DOWN : DIR_UP;

  always_comb begin
    sts.floor_ok    = (floor_r != '0) && (floor_ext <= SCAN_W'(FLOORS));
    sts.kind        = kind_r;
    sts.busy        = busy_r;
    sts.at_goal     = (floor_r == goal_r);
    sts.pick_hit    = idx_hit;
    sts.pick_last   = (dir_r == DIR_UP) ? last_dn : last_up;
    sts.scan_hit    = idx_hit;
    sts.scan_last   = scan_up_r ? last_up : last_dn;
    sts.emit_needed = (kind_r == KIND_CALL) || (stop_r != '0);
    sts.slot_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    req_nxt       = req_r;
    here_nxt      = here_r;
    goal_nxt      = goal_r;
    dir_nxt       = dir_r;
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    floor_nxt     = floor_r;
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    scan_up_nxt   = scan_up_r;
    out_stop_nxt  = out_stop_r;
    out_dir_nxt   = out_dir_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.capture) begin
      kind_nxt  = in_kind;
      floor_nxt = in_floor;
    end

    if (cmd.call) begin
      busy_nxt            = 1'b1;
      req_nxt[floor_sel]  = 1'b1;
      goal_nxt            = goal_call;
    end

    if (cmd.arrive) begin
      here_nxt           = floor_r;
      req_nxt[floor_sel] = 1'b0;
      if (floor_r == goal_r) goal_nxt = '0;
      // going up looks for the highest request, otherwise the lowest
      idx_nxt = (dir_r == DIR_UP) ? SCAN_W'(FLOORS) : SCAN_W'(1);
    end

    if (cmd.set_here) here_nxt = floor_r;

    if (cmd.pick_step) begin
      if (idx_hit) begin
        goal_nxt = FLOOR_W'(idx_r);
      end else if (!sts.pick_last) begin
        idx_nxt = (dir_r == DIR_UP) ? idx_m1 : idx_r + SCAN_W'(1);
      end
    end

    if (cmd.scan_init) begin
      idx_nxt     = SCAN_W'(here_r);
      scan_up_nxt = (goal_r > here_r);
      stop_nxt    = '0;
    end

    if (cmd.scan_step) begin
      if (idx_hit) begin
        stop_nxt = FLOOR_W'(idx_r);
      end else if (!sts.scan_last) begin
        idx_nxt = scan_up_r ? idx_r + SCAN_W'(1) : idx_m1;
      end
    end

    if (cmd.finish) begin
      if (sts.emit_needed) begin
        dir_nxt       = dir_new;
        out_valid_nxt = 1'b1;
        out_stop_nxt  = (stop_r != '0) ? stop_r : floor_r;
        out_dir_nxt   = dir_new;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      here_r      <= FLOOR_W'(1);
      goal_r      <= '0;
      dir_r       <= DIR_STAY;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_r       <= req_nxt;
      here_r      <= here_nxt;
      goal_r      <= goal_nxt;
      dir_r       <= dir_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    floor_r    <= floor_nxt;
    idx_r      <= idx_nxt;
    stop_r     <= stop_nxt;
    scan_up_r  <= scan_up_nxt;
    out_stop_r <= out_stop_nxt;
    out_dir_r  <= out_dir_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_stop_floor = out_stop_r;
  assign out_heading    = out_dir_r;

endmodule

>>> rtl/ers_checker.sv
module ers_checker import ers_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FLOOR_W-1:0] out_stop_floor,
  input logic [DIR_W-1:0]   out_heading
);

  // a pending result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // only up or down is ever reported
  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading == DIR_UP || out_heading == DIR_DOWN))
    else $error("bad heading");

  // reported stop is a real floor
  a_stop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stop_floor != '0 &&
                   SCAN_W'(out_stop_floor) <= SCAN_W'(FLOORS)))
    else $error("stop floor out of range");

  // one word at a time: input closes right after a take
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind elevator_request_scheduler ers_checker u_ers_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_stop_floor (out_chan.stop_floor),
  .out_heading    (out_chan.heading)
);
